>>> rtl/core/sqltxc_pkg.sv
// ----------------------------------------------------------------------------
// SQL transaction classifier package
// Types, constants and the per-byte scanner functions for the statement
// classifier: state encodings, keyword spellings and the verdict rule.
// ----------------------------------------------------------------------------
package sqltxc_pkg;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_KEYWORD,
		PH_AFTER_KW,
		PH_WORK,
		PH_AFTER_WK,
		PH_AFTER_SC,
		PH_FAILED
	} phase_t;

	typedef enum logic [1:0] {
		CM_NONE,
		CM_LINE,
		CM_BLOCK,
		CM_BRACE
	} comment_t;

	typedef enum logic [1:0] {
		LD_NONE,
		LD_DASH,
		LD_SLASH
	} lead_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_BEGIN,
		KIND_COMMIT,
		KIND_ROLLBACK
	} kind_t;

	typedef struct packed {
		phase_t   phase;
		kind_t    keyword_id;
		logic [3:0] match_pos;
		comment_t comment_kind;
		lead_t    pending_lead;
		logic     star_seen;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		phase:        PH_LEAD,
		keyword_id:   KIND_NONE,
		match_pos:    4'd0,
		comment_kind: CM_NONE,
		pending_lead: LD_NONE,
		star_seen:    1'b0
	};

	localparam logic [3:0] WORK_LEN = 4'd4;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DASH      = "-";
	localparam logic [7:0] CH_SLASH     = "/";
	localparam logic [7:0] CH_STAR      = "*";
	localparam logic [7:0] CH_OPEN_BR   = "{";
	localparam logic [7:0] CH_CLOSE_BR  = "}";
	localparam logic [7:0] CH_SEMICOLON = ";";
	localparam logic [7:0] CH_UNDERSCORE = "_";

	localparam logic [7:0] KW_BEGIN    [8] = '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] KW_COMMIT   [8] = '{"c", "o", "m", "m", "i", "t", 8'h00, 8'h00};
	localparam logic [7:0] KW_ROLLBACK [8] = '{"r", "o", "l", "l", "b", "a", "c", "k"};
	localparam logic [7:0] KW_WORK     [4] = '{"w", "o", "r", "k"};

	function automatic logic [7:0] lower_of(input logic [7:0] c);
		lower_of = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		logic [7:0] l;
		l = lower_of(c);
		is_word_char = (l >= "a" && l <= "z") || (c >= "0" && c <= "9")
			|| (c == CH_UNDERSCORE);
	endfunction

	function automatic logic [3:0] kw_len(input kind_t id);
		unique case (id)
			KIND_BEGIN:    kw_len = 4'd5;
			KIND_COMMIT:   kw_len = 4'd6;
			KIND_ROLLBACK: kw_len = 4'd8;
			default:       kw_len = 4'd0;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input kind_t id, input logic [2:0] pos);
		unique case (id)
			KIND_BEGIN:    kw_char = KW_BEGIN[pos];
			KIND_COMMIT:   kw_char = KW_COMMIT[pos];
			KIND_ROLLBACK: kw_char = KW_ROLLBACK[pos];
			default:       kw_char = CH_NUL;
		endcase
	endfunction

	// A byte that is neither blank nor comment, seen in a blanks phase.
	function automatic scan_state_t take_token(input scan_state_t s, input logic [7:0] c);
		scan_state_t n;
		logic [7:0]  l;
		n = s;
		l = lower_of(c);
		case (s.phase)
			PH_LEAD: begin
				n.phase     = PH_KEYWORD;
				n.match_pos = 4'd1;
				if (l == "b")      n.keyword_id = KIND_BEGIN;
				else if (l == "c") n.keyword_id = KIND_COMMIT;
				else if (l == "r") n.keyword_id = KIND_ROLLBACK;
				else begin
					n.phase     = PH_FAILED;
					n.match_pos = s.match_pos;
				end
			end
			PH_AFTER_KW: begin
				if (l == "w") begin
					n.phase     = PH_WORK;
					n.match_pos = 4'd1;
				end else if (c == CH_SEMICOLON) begin
					n.phase = PH_AFTER_SC;
				end else begin
					n.phase = PH_FAILED;
				end
			end
			PH_AFTER_WK: begin
				n.phase = (c == CH_SEMICOLON) ? PH_AFTER_SC : PH_FAILED;
			end
			default: n.phase = PH_FAILED;
		endcase
		return n;
	endfunction

	// One byte in a blanks phase: comments, pending lead-ins and whitespace.
	function automatic scan_state_t skip_byte(input scan_state_t s, input logic [7:0] c);
		scan_state_t n;
		n = s;
		if (s.comment_kind == CM_LINE) begin
			if (c == CH_NEWLINE) n.comment_kind = CM_NONE;
		end else if (s.comment_kind == CM_BLOCK) begin
			if (s.star_seen && c == CH_SLASH) begin
				n.comment_kind = CM_NONE;
				n.star_seen    = 1'b0;
			end else begin
				n.star_seen = (c == CH_STAR);
			end
		end else if (s.comment_kind == CM_BRACE) begin
			if (c == CH_CLOSE_BR) n.comment_kind = CM_NONE;
		end else if (s.pending_lead == LD_DASH) begin
			n.pending_lead = LD_NONE;
			if (c == CH_DASH) n.comment_kind = CM_LINE;
			else              n.phase        = PH_FAILED;
		end else if (s.pending_lead == LD_SLASH) begin
			n.pending_lead = LD_NONE;
			if (c == CH_STAR) begin
				n.comment_kind = CM_BLOCK;
				n.star_seen    = 1'b0;
			end else begin
				n.phase = PH_FAILED;
			end
		end else if (is_blank(c)) begin
			n = s;
		end else if (c == CH_DASH) begin
			n.pending_lead = LD_DASH;
		end else if (c == CH_SLASH) begin
			n.pending_lead = LD_SLASH;
		end else if (c == CH_OPEN_BR) begin
			n.comment_kind = CM_BRACE;
		end else begin
			n = take_token(s, c);
		end
		return n;
	endfunction

	// Full state update for one non-terminating byte.
	function automatic scan_state_t scan_step(input scan_state_t s, input logic [7:0] c);
		scan_state_t n;
		logic [3:0]  len;
		logic [7:0]  want;
		n = s;
		len = (s.phase == PH_WORK) ? WORK_LEN : kw_len(s.keyword_id);
		want = (s.phase == PH_WORK) ? KW_WORK[s.match_pos[1:0]]
			: kw_char(s.keyword_id, s.match_pos[2:0]);
		case (s.phase)
			PH_KEYWORD, PH_WORK: begin
				if (s.match_pos < len) begin
					if (lower_of(c) == want) n.match_pos = s.match_pos + 4'd1;
					else                     n.phase     = PH_FAILED;
				end else if (is_word_char(c)) begin
					n.phase = PH_FAILED;
				end else begin
					n.phase     = (s.phase == PH_WORK) ? PH_AFTER_WK : PH_AFTER_KW;
					n.match_pos = 4'd0;
					n = skip_byte(n, c);
				end
			end
			PH_LEAD, PH_AFTER_KW, PH_AFTER_WK, PH_AFTER_SC: n = skip_byte(s, c);
			default: n.phase = PH_FAILED;
		endcase
		return n;
	endfunction

	function automatic kind_t verdict(input scan_state_t s);
		logic ok;
		case (s.phase)
			PH_KEYWORD: ok = (s.match_pos == kw_len(s.keyword_id));
			PH_WORK:    ok = (s.match_pos == WORK_LEN);
			PH_AFTER_KW, PH_AFTER_WK, PH_AFTER_SC: ok = (s.pending_lead == LD_NONE);
			default:    ok = 1'b0;
		endcase
		return ok ? s.keyword_id : KIND_NONE;
	endfunction

endpackage

>>> rtl/core/sql_transaction_statement_classifier.sv
// A byte waits in the input register; a terminating zero byte then shows its verdict
// on kind from the result register, which it reaches from the input register.
// Throughput: one byte per cycle while no terminating byte is held in the input register.
// A terminating byte waits in the input register only while an earlier verdict is stalled.
// Reset (arst_n low, asynchronous) empties both registers and puts the scanner
// at the start of a statement.
// ----------------------------------------------------------------------------
// SQL transaction statement classifier
// Scans SQL text one byte per beat and, on the terminating zero byte, reports
// whether the statement was BEGIN, COMMIT or ROLLBACK (with optional WORK and ';').
// ----------------------------------------------------------------------------
module sql_transaction_statement_classifier (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          ch,
	output logic                out_valid,
	input  logic                out_stall,
	output sqltxc_pkg::kind_t   kind
);
	import sqltxc_pkg::*;

	// Input register: one byte beat waiting to be scanned.
	logic        valid_s1;
	logic [7:0]  ch_s1;

	// Scanner state carried from byte to byte within a statement.
	scan_state_t state_q;

	// Result register: the verdict beat offered downstream.
	logic        out_valid_q;
	kind_t       kind_q;

	logic        is_end_s1;
	logic        blocked;
	logic        take_s1;
	logic        accept;
	scan_state_t state_next;

	assign is_end_s1 = (ch_s1 == CH_NUL);

	// Only a terminating byte needs the result register, so ordinary text
	// keeps flowing even while a verdict is held up downstream.
	assign blocked  = valid_s1 && is_end_s1 && out_valid_q && out_stall;
	assign take_s1  = valid_s1 && !blocked;
	assign in_stall = blocked;
	assign accept   = in_valid && !in_stall;

	// The whole per-byte update is a short combinational step.
	assign state_next = scan_step(state_q, ch_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= ch;
		end
	end

	// The terminating byte returns the scanner to the start of a statement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_RESET;
		end else if (take_s1) begin
			state_q <= is_end_s1 ? SCAN_RESET : state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1 && is_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && is_end_s1) begin
			kind_q <= verdict(state_q);
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;

	// A terminating byte always leaves the scanner at the start of a statement.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && is_end_s1 |=> state_q == SCAN_RESET)
		else $error("scanner not reset after end of statement");

	// Ordinary text never raises a verdict.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && !is_end_s1 && !out_valid_q |=> !out_valid_q)
		else $error("verdict raised without a terminating byte");

	// A failed statement stays failed until its end.
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && !is_end_s1 && state_q.phase == PH_FAILED |=> state_q.phase == PH_FAILED)
		else $error("failure not sticky");

	// Inside a comment no dash or slash lead-in can be pending.
	a_comment_no_lead: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.comment_kind != CM_NONE |-> state_q.pending_lead == LD_NONE)
		else $error("lead-in pending inside a comment");

endmodule

>>> sim/tb_sql_transaction_statement_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the SQL transaction statement classifier
// Feeds SQL text byte by byte: a directed set of statements, then random
// statements, most of them well formed and some mutated or pure noise.
// Every accepted byte goes through a scanner model kept in the bench. Each
// accepted verdict is checked against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_sql_transaction_statement_classifier;

	import sqltxc_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_BYTES  = 750;     // random text on top of the directed set
	localparam int CALM_TAIL     = 150;     // final beats sent and taken with no idling
	localparam int HOLD_CYCLES   = 60;      // the one long hold-off on the result side
	localparam int DRAIN_CYCLES  = 8;       // wait after the last verdict, with margin
	localparam int CYCLE_LIMIT   = 200000;

	localparam logic [7:0] NL = 8'h0A;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  ch        = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	kind_t       kind;

	sql_transaction_statement_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Text waiting to be sent, the statement being built, and the verdicts
	// still owed by the block, oldest first.
	logic [7:0] byte_q[$];
	logic [7:0] stmt_buf[$];
	kind_t      expected_kinds[$];

	int total_bytes;
	int statements;
	int calm_from;
	int burst_at;
	int bytes_accepted;
	int send_gap;
	int stall_left;
	int hold_left;
	logic hold_done;
	int input_backpressure;
	int cycle_count;
	int faults;
	int kind_tally[4];

	// ------------------------------------------------------------------
	// Scanner model. It keeps its own copy of the block's state and moves
	// it on by one byte for every beat accepted on the input side.
	// ------------------------------------------------------------------
	phase_t     sc_phase = PH_LEAD;
	kind_t      sc_word  = KIND_NONE;
	logic [3:0] sc_pos   = 4'd0;
	comment_t   sc_cmt   = CM_NONE;
	lead_t      sc_lead  = LD_NONE;
	logic       sc_star  = 1'b0;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Letters, digits and underscore may not follow a keyword directly.
	function automatic logic ident_byte(input logic [7:0] c);
		logic [7:0] f;
		f = fold_case(c);
		return (f >= "a" && f <= "z") || (c >= "0" && c <= "9") || c == "_";
	endfunction

	function automatic string spelling(input kind_t w);
		case (w)
			KIND_BEGIN:    return "begin";
			KIND_COMMIT:   return "commit";
			KIND_ROLLBACK: return "rollback";
			default:       return "";
		endcase
	endfunction

	task automatic reset_scanner();
		sc_phase = PH_LEAD;
		sc_word  = KIND_NONE;
		sc_pos   = 4'd0;
		sc_cmt   = CM_NONE;
		sc_lead  = LD_NONE;
		sc_star  = 1'b0;
	endtask

	// A byte that starts a token in one of the blank-skipping phases.
	task automatic start_token(input logic [7:0] c);
		logic [7:0] f;
		f = fold_case(c);
		case (sc_phase)
			PH_LEAD: begin
				if (f == "b")      sc_word = KIND_BEGIN;
				else if (f == "c") sc_word = KIND_COMMIT;
				else if (f == "r") sc_word = KIND_ROLLBACK;
				if (f == "b" || f == "c" || f == "r") begin
					sc_phase = PH_KEYWORD;
					sc_pos   = 4'd1;
				end else begin
					sc_phase = PH_FAILED;
				end
			end
			PH_AFTER_KW: begin
				if (f == "w") begin
					sc_phase = PH_WORK;
					sc_pos   = 4'd1;
				end else if (c == ";") begin
					sc_phase = PH_AFTER_SC;
				end else begin
					sc_phase = PH_FAILED;
				end
			end
			PH_AFTER_WK: sc_phase = (c == ";") ? PH_AFTER_SC : PH_FAILED;
			default:     sc_phase = PH_FAILED;
		endcase
	endtask

	// Whitespace, comments and their two-byte openers, between tokens.
	task automatic skip_blanks(input logic [7:0] c);
		case (sc_cmt)
			CM_LINE: begin
				if (c == NL) sc_cmt = CM_NONE;
			end
			CM_BLOCK: begin
				if (sc_star && c == "/") begin
					sc_cmt  = CM_NONE;
					sc_star = 1'b0;
				end else begin
					sc_star = (c == "*");
				end
			end
			CM_BRACE: begin
				if (c == "}") sc_cmt = CM_NONE;
			end
			default: begin
				if (sc_lead == LD_DASH) begin
					sc_lead = LD_NONE;
					if (c == "-") sc_cmt = CM_LINE;
					else          sc_phase = PH_FAILED;
				end else if (sc_lead == LD_SLASH) begin
					sc_lead = LD_NONE;
					if (c == "*") begin
						sc_cmt  = CM_BLOCK;
						sc_star = 1'b0;
					end else begin
						sc_phase = PH_FAILED;
					end
				end else if (c == "-") begin
					sc_lead = LD_DASH;
				end else if (c == "/") begin
					sc_lead = LD_SLASH;
				end else if (c == "{") begin
					sc_cmt = CM_BRACE;
				end else if (!is_space(c)) begin
					start_token(c);
				end
			end
		endcase
	endtask

	// Matching the keyword or WORK; once the word is complete, the next byte
	// must end it and is then handled as a blank-phase byte.
	task automatic match_word(input logic [7:0] c, input string spell, input phase_t after);
		if (sc_pos < spell.len()) begin
			if (fold_case(c) == spell[sc_pos]) sc_pos = sc_pos + 4'd1;
			else                               sc_phase = PH_FAILED;
		end else if (ident_byte(c)) begin
			sc_phase = PH_FAILED;
		end else begin
			sc_phase = after;
			sc_pos   = 4'd0;
			skip_blanks(c);
		end
	endtask

	function automatic kind_t closing_kind();
		logic ok;
		case (sc_phase)
			PH_KEYWORD:                            ok = (sc_pos == spelling(sc_word).len());
			PH_WORK:                               ok = (sc_pos == 4'd4);
			PH_AFTER_KW, PH_AFTER_WK, PH_AFTER_SC: ok = (sc_lead == LD_NONE);
			default:                               ok = 1'b0;
		endcase
		return ok ? sc_word : KIND_NONE;
	endfunction

	// One accepted byte. The zero byte closes the statement and owes a verdict.
	task automatic classify_byte(input logic [7:0] c);
		kind_t v;
		if (c == 8'h00) begin
			v = closing_kind();
			expected_kinds.push_back(v);
			kind_tally[v]++;
			reset_scanner();
		end else begin
			case (sc_phase)
				PH_KEYWORD: match_word(c, spelling(sc_word), PH_AFTER_KW);
				PH_WORK:    match_word(c, "work", PH_AFTER_WK);
				PH_LEAD, PH_AFTER_KW, PH_AFTER_WK, PH_AFTER_SC: skip_blanks(c);
				default:    sc_phase = PH_FAILED;
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Statement building. Text collects in stmt_buf and is moved to the
	// send queue with its terminating zero byte.
	// ------------------------------------------------------------------
	task automatic add_text(input string t);
		for (int i = 0; i < t.len(); i++) stmt_buf.push_back(t[i]);
	endtask

	// A word with the case of each letter chosen at random.
	task automatic add_word(input string w);
		logic [7:0] b;
		for (int i = 0; i < w.len(); i++) begin
			b = w[i];
			if (b >= "a" && b <= "z" && $urandom_range(0, 1) == 1) b = b - 8'd32;
			stmt_buf.push_back(b);
		end
	endtask

	// Comment body: mostly printable text, now and then a byte above 127.
	task automatic add_filler();
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 7) == 0) stmt_buf.push_back(8'($urandom_range(128, 255)));
			else                           stmt_buf.push_back(8'($urandom_range(32, 126)));
		end
	endtask

	task automatic add_blanks(input int min_pieces);
		logic [7:0] spaces[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		repeat ($urandom_range(min_pieces, 3)) begin
			case ($urandom_range(0, 5))
				0, 1, 2: stmt_buf.push_back(spaces[$urandom_range(0, 5)]);
				3: begin
					add_text("--");
					add_filler();
					stmt_buf.push_back(NL);
				end
				4: begin
					add_text("/*");
					add_filler();
					add_text("*/");
				end
				default: begin
					add_text("{");
					add_filler();
					add_text("}");
				end
			endcase
		end
	endtask

	// A comment left open at the end of the statement.
	task automatic add_open_comment();
		case ($urandom_range(0, 3))
			0:       add_text("--");
			1:       add_text("/*");
			2:       add_text("{");
			default: add_text("/**");
		endcase
		add_filler();
	endtask

	task automatic close_statement();
		foreach (stmt_buf[i]) byte_q.push_back(stmt_buf[i]);
		byte_q.push_back(8'h00);
		stmt_buf.delete();
		statements++;
	endtask

	task automatic statement(input string t);
		add_text(t);
		close_statement();
	endtask

	// Most random statements are well formed with random blanks, comments and
	// letter case; one in five of all statements is then damaged, and some are pure noise.
	task automatic add_random_statement();
		int shape;
		int idx;
		shape = $urandom_range(0, 99);
		if (shape < 12) begin
			repeat ($urandom_range(1, 10)) stmt_buf.push_back(8'($urandom_range(1, 255)));
		end else begin
			add_blanks(0);
			add_word(spelling(kind_t'($urandom_range(1, 3))));
			if ($urandom_range(0, 1) == 1) begin
				add_blanks(1);
				add_word("work");
			end
			add_blanks(0);
			if ($urandom_range(0, 1) == 1) add_text(";");
			add_blanks(0);
			if ($urandom_range(0, 5) == 0) add_open_comment();
			if (shape >= 80 && stmt_buf.size() != 0) begin
				idx = $urandom_range(0, stmt_buf.size() - 1);
				case ($urandom_range(0, 2))
					0: stmt_buf[idx] = 8'($urandom_range(1, 255));
					1: while (stmt_buf.size() > idx) void'(stmt_buf.pop_back());
					default: begin
						if ($urandom_range(0, 1) == 1) stmt_buf.insert(idx, "_");
						else stmt_buf.insert(idx, 8'($urandom_range(1, 255)));
					end
				endcase
			end
		end
		close_statement();
	endtask

	task automatic build_stimulus();
		int random_start;
		logic burst_placed;
		burst_placed = 1'b0;

		// Directed statements: each keyword, case mixing, every blank byte,
		// all three comment styles, WORK and the semicolon.
		statement("begin");
		statement("COMMIT");
		statement("RoLlBaCk");
		stmt_buf = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		add_text("begin");
		stmt_buf.push_back(8'h0D);
		close_statement();
		statement("commit work;");
		statement("ROLLBACK WORK");
		statement("--x\n/* c **/{ br }begin/*a*/work{}; ");
		statement("BEGIN\tWORK");
		statement("commit--x");
		// Keyword run straight into a letter, underscore or digit.
		statement("beginx");
		statement("commit_");
		statement("rollback9");
		// Lone dash or slash, also right before the end.
		statement("begin-");
		statement("commit /");
		statement("begin -x");
		// The star that opens a block comment cannot close it as well.
		statement("/*/*/commit");
		// Comments still open at the end of the statement.
		statement("rollback;  -- done");
		statement("commit /* open");
		statement("rollback{x}work{");
		// Partial words, stray words, doubled semicolon, sticky failure.
		statement("beg");
		statement("begin w");
		statement("work");
		statement("begin work work");
		statement("begin;;");
		statement("xbegin");
		statement("");
		// Bytes above 127 are neither letters nor blanks.
		add_text("begin");
		stmt_buf.push_back(8'hC2);
		close_statement();
		stmt_buf = '{8'hFF, 8'h80};
		close_statement();

		random_start = byte_q.size();
		while (byte_q.size() < random_start + RANDOM_BYTES) begin
			if (!burst_placed && byte_q.size() >= random_start + RANDOM_BYTES / 2) begin
				// A run of empty statements offered while the result side is held
				// off, so that the block fills and pushes back on its input.
				burst_at = byte_q.size();
				repeat (12) close_statement();
				burst_placed = 1'b1;
			end
			add_random_statement();
		end
		total_bytes = byte_q.size();
		calm_from   = total_bytes - CALM_TAIL;
	endtask

	// ------------------------------------------------------------------
	// Sender. A beat is accepted at an edge with in_valid high and in_stall
	// low; only then is the next byte put up. Idle bursts are drawn only
	// between beats, so a held byte never changes and in_valid never falls
	// while it waits.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch       <= 8'h00;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				classify_byte(ch);
				bytes_accepted <= bytes_accepted + 1;
			end
			if (in_valid && in_stall) input_backpressure++;
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (byte_q.size() != 0 && bytes_accepted < calm_from
						&& $urandom_range(0, 9) == 0) begin
					// An idle burst starts here; send_gap holds how much of it is left.
					send_gap <= $urandom_range(0, 6);
					in_valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					in_valid <= 1'b1;
					ch       <= byte_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The long hold-off on the result side, counted here on its own. It
	// starts as the run of empty statements begins to go in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && bytes_accepted >= burst_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Receiver. Checks every accepted verdict against the oldest one owed,
	// then decides whether to stall the next cycle: the long hold-off, a
	// short random burst, or none in the last part of the run.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		kind_t owed;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_kinds.size() == 0) begin
					$error("kind: expected no result, got %0d", kind);
					faults++;
				end else begin
					owed = expected_kinds.pop_front();
					if (kind !== owed) begin
						$error("kind: expected %0d, got %0d", owed, kind);
						faults++;
					end
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else if (bytes_accepted < calm_from && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 6);
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a verdict that never comes or a stalled input ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_sql_transaction_statement_classifier failed");
			$finish;
		end
	end

	initial begin
		// burst_at is kept out of reach until the stimulus sets it.
		burst_at  = 32'h7FFF_FFFF;
		calm_from = 32'h7FFF_FFFF;
		build_stimulus();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// Every byte taken and every verdict returned; then a drain wait
		// to catch any result the block should not have produced.
		while (bytes_accepted != total_bytes || expected_kinds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in %0d statements: begin %0d, commit %0d, rollback %0d, none %0d.",
			total_bytes, statements, kind_tally[KIND_BEGIN], kind_tally[KIND_COMMIT],
			kind_tally[KIND_ROLLBACK], kind_tally[KIND_NONE]);
		$display("The block held back its input on %0d cycles; %0d mismatches.",
			input_backpressure, faults);
		if (faults == 0) begin
			$display("tb_sql_transaction_statement_classifier passed");
		end else begin
			$display("tb_sql_transaction_statement_classifier failed");
		end
		$finish;
	end

endmodule
